FILE: rtl/lmf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmf_pkg: shared types and constants of the line message FIFO
// Word classes, result status codes, back-end states and default sizes.
// ---------------------------------------------------------------------------
package lmf_pkg;

	// Default geometry of the message store
	localparam int MSG_LEN_DEF   = 256;
	localparam int MSG_SLOTS_DEF = 32;

	// Depth of the queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Line terminator on the link
	localparam logic [7:0] NEWLINE_CODE = 8'h0A;

	// Fixed result field widths
	localparam int HLEN_W  = 9;
	localparam int COUNT_W = 6;

	// Class of an accepted word, decided by the front
	typedef enum logic [1:0] {
		KIND_IGNORE,
		KIND_DATA,
		KIND_NEWLINE,
		KIND_READ
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_EMPTY,
		STATUS_DROP
	} status_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_STORE_RD,
		BK_LEN_RD
	} back_state_t;

	// One classified word travelling through the queue
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

endpackage

FILE: rtl/lmf_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmf_ram: generic simple dual-port RAM
// One write port, one read port with registered read data held between reads.
// ---------------------------------------------------------------------------
module lmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, hold data until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/lmf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmf_front: input stage of the line message FIFO
// Accepts words from the link side, classifies them and pushes them on.
// ---------------------------------------------------------------------------
module lmf_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           mode,
	input  logic [7:0]     rx_byte,
	input  logic           q_full,
	output logic           q_push,
	output lmf_pkg::item_t q_item
);

	logic           valid_s1;
	lmf_pkg::item_t item_s1;
	lmf_pkg::item_t item_dec;
	logic           accept;

	// Classify the incoming word
	always_comb begin
		item_dec.data = rx_byte;
		if (mode) begin
			item_dec.kind = lmf_pkg::KIND_READ;
		end else if (rx_byte == 8'h00) begin
			item_dec.kind = lmf_pkg::KIND_IGNORE;
		end else if (rx_byte == lmf_pkg::NEWLINE_CODE) begin
			item_dec.kind = lmf_pkg::KIND_NEWLINE;
		end else begin
			item_dec.kind = lmf_pkg::KIND_DATA;
		end
	end

	// Stall only while the stage holds a word the queue cannot take
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = valid_s1 && !q_full;
	assign q_item   = item_s1;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_dec;
		end
	end

endmodule

FILE: rtl/lmf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmf_queue: short FIFO between front and back
// Decouples word acceptance from message store work.
// ---------------------------------------------------------------------------
module lmf_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lmf_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output lmf_pkg::item_t pop_item
);

	localparam int PTR_W = $clog2(lmf_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(lmf_pkg::QUEUE_DEPTH + 1);

	lmf_pkg::item_t   entry_q [lmf_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(lmf_pkg::QUEUE_DEPTH));
	assign valid    = (count_q != '0);
	assign pop_item = entry_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

FILE: rtl/lmf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lmf_back: message store sequencer of the line message FIFO
// Carries out classified words against the store and the length table and
// registers one result per word.
// ---------------------------------------------------------------------------
module lmf_back #(
	parameter int MSG_LEN   = lmf_pkg::MSG_LEN_DEF,
	parameter int MSG_SLOTS = lmf_pkg::MSG_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  lmf_pkg::item_t              q_item,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  read_byte,
	output logic                        read_last,
	output logic [1:0]                  status,
	output logic                        line_done,
	output logic [lmf_pkg::HLEN_W-1:0]  head_length,
	output logic [lmf_pkg::COUNT_W-1:0] message_count
);

	localparam int LEN_W  = $clog2(MSG_LEN + 1);
	localparam int IDX_W  = $clog2(MSG_LEN);
	localparam int SLOT_W = $clog2(MSG_SLOTS);
	localparam int CNT_W  = $clog2(MSG_SLOTS + 1);
	localparam int DEPTH  = MSG_LEN * MSG_SLOTS;
	localparam int ADDR_W = $clog2(DEPTH);

	lmf_pkg::back_state_t state_q, state_d;

	logic [SLOT_W-1:0] head_slot_q, head_slot_d;
	logic [SLOT_W-1:0] tail_slot_q, tail_slot_d;
	logic [ADDR_W-1:0] head_base_q, head_base_d;
	logic [ADDR_W-1:0] tail_base_q, tail_base_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [IDX_W-1:0]  asm_idx_q, asm_idx_d;
	logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
	logic [LEN_W-1:0]  head_len_q, head_len_d;

	logic                        out_valid_q;
	logic [7:0]                  read_byte_q;
	logic                        read_last_q;
	lmf_pkg::status_t            status_q;
	logic                        line_done_q;
	logic [lmf_pkg::HLEN_W-1:0]  head_length_q;
	logic [lmf_pkg::COUNT_W-1:0] message_count_q;

	// Store and length table ports
	logic              store_we, store_re;
	logic [ADDR_W-1:0] store_waddr, store_raddr;
	logic [7:0]        store_rdata;
	logic              len_we, len_re;
	logic [SLOT_W-1:0] len_waddr, len_raddr;
	logic [LEN_W-1:0]  len_wdata, len_rdata;

	// Result being loaded
	logic             load;
	logic [7:0]       r_byte;
	logic             r_last;
	lmf_pkg::status_t r_status;
	logic             r_done;
	logic [LEN_W-1:0] r_hlen;
	logic [CNT_W-1:0] r_cnt;

	logic [LEN_W+lmf_pkg::HLEN_W-1:0]   r_hlen_wide;
	logic [CNT_W+lmf_pkg::COUNT_W-1:0]  r_cnt_wide;

	// Decoded conditions
	logic              out_free, start;
	logic              count_nz, queue_full, line_full, read_end, last_msg;
	logic [LEN_W-1:0]  new_len;
	logic [SLOT_W-1:0] head_slot_inc, tail_slot_inc;
	logic [ADDR_W-1:0] head_base_inc, tail_base_inc;
	logic              head_wrap, tail_wrap;

	assign out_free   = !out_valid_q || !out_stall;
	assign start      = (state_q == lmf_pkg::BK_IDLE) && q_valid && out_free;
	assign count_nz   = (count_q != '0);
	assign queue_full = (count_q == CNT_W'(MSG_SLOTS));
	assign line_full  = (asm_idx_q >= IDX_W'(MSG_LEN - 2));
	assign read_end   = ((LEN_W'(rd_idx_q) + LEN_W'(1)) >= head_len_q);
	assign last_msg   = (count_q == CNT_W'(1));
	assign new_len    = LEN_W'(asm_idx_q) + LEN_W'(2);

	// Slot pointers wrap at the slot count, bases follow them
	assign head_wrap     = (head_slot_q == SLOT_W'(MSG_SLOTS - 1));
	assign tail_wrap     = (tail_slot_q == SLOT_W'(MSG_SLOTS - 1));
	assign head_slot_inc = head_wrap ? '0 : head_slot_q + SLOT_W'(1);
	assign tail_slot_inc = tail_wrap ? '0 : tail_slot_q + SLOT_W'(1);
	assign head_base_inc = head_wrap ? '0 : head_base_q + ADDR_W'(MSG_LEN);
	assign tail_base_inc = tail_wrap ? '0 : tail_base_q + ADDR_W'(MSG_LEN);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lmf_pkg::BK_IDLE: begin
				if (start && q_item.kind == lmf_pkg::KIND_READ && count_nz) begin
					if (!read_end) begin
						state_d = lmf_pkg::BK_STORE_RD;
					end else if (!last_msg) begin
						state_d = lmf_pkg::BK_LEN_RD;
					end
				end
			end
			lmf_pkg::BK_STORE_RD, lmf_pkg::BK_LEN_RD: begin
				if (out_free) begin
					state_d = lmf_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lmf_pkg::BK_IDLE;
			end
		endcase
	end

	// Actions, memory requests and result fields
	always_comb begin
		q_pop       = start;
		store_we    = 1'b0;
		store_waddr = tail_base_q + ADDR_W'(asm_idx_q);
		store_re    = 1'b0;
		store_raddr = head_base_q + ADDR_W'(rd_idx_q);
		len_we      = 1'b0;
		len_waddr   = tail_slot_q;
		len_wdata   = new_len;
		len_re      = 1'b0;
		len_raddr   = head_slot_inc;

		head_slot_d = head_slot_q;
		tail_slot_d = tail_slot_q;
		head_base_d = head_base_q;
		tail_base_d = tail_base_q;
		count_d     = count_q;
		asm_idx_d   = asm_idx_q;
		rd_idx_d    = rd_idx_q;
		head_len_d  = head_len_q;

		load     = 1'b0;
		r_byte   = 8'h00;
		r_last   = 1'b0;
		r_status = lmf_pkg::STATUS_OK;
		r_done   = 1'b0;
		r_hlen   = count_nz ? head_len_q : '0;
		r_cnt    = count_q;

		unique case (state_q)
			lmf_pkg::BK_IDLE: begin
				if (start) begin
					unique case (q_item.kind)
						lmf_pkg::KIND_IGNORE: begin
							load = 1'b1;
						end
						lmf_pkg::KIND_DATA: begin
							load = 1'b1;
							if (queue_full || line_full) begin
								r_status = lmf_pkg::STATUS_DROP;
							end else begin
								store_we  = 1'b1;
								asm_idx_d = asm_idx_q + IDX_W'(1);
							end
						end
						lmf_pkg::KIND_NEWLINE: begin
							load = 1'b1;
							if (queue_full) begin
								r_status = lmf_pkg::STATUS_DROP;
							end else begin
								// close the line and queue it
								store_we    = 1'b1;
								len_we      = 1'b1;
								tail_slot_d = tail_slot_inc;
								tail_base_d = tail_base_inc;
								count_d     = count_q + CNT_W'(1);
								asm_idx_d   = '0;
								r_done      = 1'b1;
								r_cnt       = count_q + CNT_W'(1);
								if (!count_nz) begin
									head_len_d = new_len;
									r_hlen     = new_len;
								end
							end
						end
						lmf_pkg::KIND_READ: begin
							if (!count_nz) begin
								load     = 1'b1;
								r_status = lmf_pkg::STATUS_EMPTY;
							end else if (read_end) begin
								// terminator: pop the oldest message
								head_slot_d = head_slot_inc;
								head_base_d = head_base_inc;
								count_d     = count_q - CNT_W'(1);
								rd_idx_d    = '0;
								if (last_msg) begin
									load   = 1'b1;
									r_last = 1'b1;
									r_hlen = '0;
									r_cnt  = '0;
								end else begin
									len_re = 1'b1;
								end
							end else begin
								store_re = 1'b1;
								rd_idx_d = rd_idx_q + IDX_W'(1);
							end
						end
						default: begin
							load = 1'b0;
						end
					endcase
				end
			end
			lmf_pkg::BK_STORE_RD: begin
				r_byte = store_rdata;
				load   = out_free;
			end
			lmf_pkg::BK_LEN_RD: begin
				// length of the new oldest message arrives
				head_len_d = len_rdata;
				r_hlen     = len_rdata;
				r_last     = 1'b1;
				load       = out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	// Sequencer and pointer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lmf_pkg::BK_IDLE;
			head_slot_q <= '0;
			tail_slot_q <= '0;
			head_base_q <= '0;
			tail_base_q <= '0;
			count_q     <= '0;
			asm_idx_q   <= '0;
			rd_idx_q    <= '0;
			head_len_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			head_slot_q <= head_slot_d;
			tail_slot_q <= tail_slot_d;
			head_base_q <= head_base_d;
			tail_base_q <= tail_base_d;
			count_q     <= count_d;
			asm_idx_q   <= asm_idx_d;
			rd_idx_q    <= rd_idx_d;
			head_len_q  <= head_len_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Fit result counts to the port widths
	assign r_hlen_wide = (LEN_W + lmf_pkg::HLEN_W)'(r_hlen);
	assign r_cnt_wide  = (CNT_W + lmf_pkg::COUNT_W)'(r_cnt);

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			read_byte_q     <= r_byte;
			read_last_q     <= r_last;
			status_q        <= r_status;
			line_done_q     <= r_done;
			head_length_q   <= r_hlen_wide[lmf_pkg::HLEN_W-1:0];
			message_count_q <= r_cnt_wide[lmf_pkg::COUNT_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign read_byte     = read_byte_q;
	assign read_last     = read_last_q;
	assign status        = status_q;
	assign line_done     = line_done_q;
	assign head_length   = head_length_q;
	assign message_count = message_count_q;

	// Character store
	lmf_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (store_we),
		.waddr(store_waddr),
		.wdata(q_item.data),
		.re   (store_re),
		.raddr(store_raddr),
		.rdata(store_rdata)
	);

	// Message length table
	lmf_ram #(
		.WIDTH(LEN_W),
		.DEPTH(MSG_SLOTS)
	) u_lengths (
		.clk  (clk),
		.we   (len_we),
		.waddr(len_waddr),
		.wdata(len_wdata),
		.re   (len_re),
		.raddr(len_raddr),
		.rdata(len_rdata)
	);

endmodule

FILE: rtl/line_message_fifo_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_message_fifo_top: receive-side FIFO of newline-terminated messages
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------------------
//   in      | in_valid / in_stall  | mode, rx_byte
//   out     | out_valid / out_stall| read_byte, read_last, status, line_done,
//           |                      | head_length, message_count
//
// A received byte, an ignored zero byte and a read of an empty queue are done
// in the idle state. Reading a stored character waits in BK_STORE_RD on the
// registered read of the character store; a terminator that leaves further
// messages queued waits in BK_LEN_RD on the registered length-table read.
// The front stage and a four-word queue keep taking words while the back end
// waits on a stalled result. Reset clears state, pointers and counts only; the store
// and the length table need no clearing pass.
// ---------------------------------------------------------------------------
module line_message_fifo_top #(
	parameter int MSG_LEN   = lmf_pkg::MSG_LEN_DEF,
	parameter int MSG_SLOTS = lmf_pkg::MSG_SLOTS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  read_byte,
	output logic                        read_last,
	output logic [1:0]                  status,
	output logic                        line_done,
	output logic [lmf_pkg::HLEN_W-1:0]  head_length,
	output logic [lmf_pkg::COUNT_W-1:0] message_count
);

	logic           q_push;
	lmf_pkg::item_t q_push_item;
	logic           q_full;
	logic           q_pop;
	logic           q_valid;
	lmf_pkg::item_t q_pop_item;

	// Accept and classify
	lmf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode    (mode),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_push_item)
	);

	// Decouple front and back
	lmf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(q_push_item),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.pop_item (q_pop_item)
	);

	// Carry out against the message store
	lmf_back #(
		.MSG_LEN  (MSG_LEN),
		.MSG_SLOTS(MSG_SLOTS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_pop_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_byte    (read_byte),
		.read_last    (read_last),
		.status       (status),
		.line_done    (line_done),
		.head_length  (head_length),
		.message_count(message_count)
	);

	// A terminator word carries a zero byte and an ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_last |->
			read_byte == 8'h00 && status == lmf_pkg::STATUS_OK)
		else $error("terminator word with data or bad status");

	// A read of an empty queue reports no head message
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == lmf_pkg::STATUS_EMPTY |->
			head_length == '0 && !read_last && !line_done)
		else $error("empty read reports a head message");

	// A completed line is never also a read result or a drop
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |->
			!read_last && status == lmf_pkg::STATUS_OK && head_length != '0)
		else $error("line completion with inconsistent fields");

	// The front never pushes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

endmodule
